### hw/rtl/assert_macros.svh
// Assertion helpers used by lut3d_back; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define LUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true out of reset.
`define LUT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/lut3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_pkg
// Types and constants of the 3D LUT trilinear interpolator.
// ----------------------------------------------------------------------------
package lut3d_pkg;

  localparam int MAX_GRID_DEF = 17;
  localparam int GRID_W       = 5;
  localparam logic [GRID_W-1:0] GRID_RESET = 5'd17;
  localparam int POS_W        = 15;   // g <= 31, so g^3 - 1 fits
  localparam int SQ_W         = 10;
  localparam int FAC_W        = 17;
  localparam int ACC_W        = 37;
  localparam logic [FAC_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_PIXEL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic               cmd;
    logic [12:0]        entry_index;
    logic [1:0]         entry_channel;
    logic signed [15:0] entry_value;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
  } item_t;

  typedef struct packed {
    logic signed [15:0] chan0;
    logic signed [15:0] chan1;
    logic signed [15:0] chan2;
    logic signed [15:0] chan3;
  } result_t;

  typedef struct packed {
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [1:0]         chan;
    logic signed [15:0] value;
    logic [15:0]        frac0;
    logic [15:0]        frac1;
    logic [15:0]        frac2;
  } job_t;

endpackage

### hw/rtl/lut3d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_front
// Accepts transactions, splits pixels into cell base and fractions, drops
// out-of-range loads and hands jobs to the queue.
// ----------------------------------------------------------------------------
module lut3d_front #(
  parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  lut3d_pkg::item_t               item,
  input  logic [lut3d_pkg::GRID_W-1:0]   geff,
  input  logic [lut3d_pkg::SQ_W-1:0]     gsq,
  output logic                           job_valid,
  input  logic                           job_ready,
  output lut3d_pkg::job_t                job
);

  localparam int SPAN = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int MW   = 16 + lut3d_pkg::GRID_W;

  logic                           s1_valid;
  lut3d_pkg::op_t                 s1_op;
  logic [12:0]                    s1_index;
  logic [1:0]                     s1_chan;
  logic signed [15:0]             s1_value;
  logic [lut3d_pkg::GRID_W-1:0]   s1_idx [3];
  logic [15:0]                    s1_frac [3];

  logic [lut3d_pkg::GRID_W-1:0]   gm1;
  logic [MW-1:0]                  scaled [3];
  logic [15:0]                    comp [3];
  logic                           advance;
  logic [lut3d_pkg::POS_W-1:0]    base;

  assign gm1     = geff - lut3d_pkg::GRID_W'(1);
  assign comp[0] = item.red;
  assign comp[1] = item.green;
  assign comp[2] = item.blue;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      scaled[a] = MW'(comp[a]) * MW'(gm1);
    end
  end

  assign advance    = !s1_valid || (s1_op == lut3d_pkg::OP_NONE) || job_ready;
  assign item_ready = advance;
  assign job_valid  = s1_valid && (s1_op != lut3d_pkg::OP_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      if (item.cmd == lut3d_pkg::CMD_PIXEL) begin
        s1_op <= lut3d_pkg::OP_PIXEL;
      end else if (32'(item.entry_index) < SPAN) begin
        s1_op <= lut3d_pkg::OP_LOAD;
      end else begin
        s1_op <= lut3d_pkg::OP_NONE;
      end
      s1_index <= item.entry_index;
      s1_chan  <= item.entry_channel;
      s1_value <= item.entry_value;
      for (int a = 0; a < 3; a++) begin
        s1_idx[a]  <= scaled[a][MW-1:16];
        s1_frac[a] <= scaled[a][15:0];
      end
    end
  end

  assign base = lut3d_pkg::POS_W'(s1_idx[0])
              + lut3d_pkg::POS_W'(s1_idx[1]) * lut3d_pkg::POS_W'(geff)
              + lut3d_pkg::POS_W'(s1_idx[2]) * lut3d_pkg::POS_W'(gsq);

  always_comb begin
    job.op    = s1_op;
    job.pos   = (s1_op == lut3d_pkg::OP_PIXEL) ? base : lut3d_pkg::POS_W'(s1_index);
    job.chan  = s1_chan;
    job.value = s1_value;
    job.frac0 = s1_frac[0];
    job.frac1 = s1_frac[1];
    job.frac2 = s1_frac[2];
  end

endmodule

### hw/rtl/lut3d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module lut3d_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  lut3d_pkg::job_t push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output lut3d_pkg::job_t pop_job
);

  lut3d_pkg::job_t slots [2];
  logic [1:0]      count;
  logic            rd_ptr;
  logic            wr_ptr;
  logic            push;
  logic            pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

### hw/rtl/lut3d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_back
// Holds the table, performs loads and runs the eight-corner weighted sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lut3d_back #(
  parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  lut3d_pkg::job_t                job,
  input  logic [lut3d_pkg::GRID_W-1:0]   geff,
  input  logic [lut3d_pkg::SQ_W-1:0]     gsq,
  output logic                           result_valid,
  input  logic                           result_ready,
  output lut3d_pkg::result_t             result
);

  localparam int SPAN = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW   = $clog2(SPAN);
  localparam int FW   = lut3d_pkg::FAC_W;
  localparam int AccW = lut3d_pkg::ACC_W;

  logic [3:0][15:0] mem [SPAN];

  lut3d_pkg::back_state_t state, state_next;
  lut3d_pkg::job_t        cur;
  logic [2:0]             k;
  logic                   q_pop;
  logic                   wr_en;
  logic                   rd_en;
  logic                   start;
  logic                   finish;
  logic [lut3d_pkg::POS_W-1:0] offset;
  logic [AW-1:0]          rd_addr;
  logic [3:0][15:0]       rd_data;

  logic [FW-1:0]          fa, fb, fc;
  logic                   v1, v2, v3;
  logic [2*FW-1:0]        p01;
  logic [FW-1:0]          f2_1;
  logic [3*FW-1:0]        p012;
  logic [FW-1:0]          w;
  logic [3:0][15:0]       d2;
  logic signed [FW+16:0]  prod [4];
  logic signed [AccW-1:0] acc [4];
  logic signed [AccW-1:0] rnd [4];
  logic signed [15:0]     sat [4];

  assign q_pop     = job_valid && job_ready;
  assign job_ready = (state == lut3d_pkg::ST_IDLE);
  assign wr_en     = q_pop && (job.op == lut3d_pkg::OP_LOAD);
  assign start     = q_pop && (job.op == lut3d_pkg::OP_PIXEL);
  assign rd_en     = (state == lut3d_pkg::ST_RUN);
  assign finish    = (state == lut3d_pkg::ST_DONE) && (!result_valid || result_ready);

  always_comb begin
    state_next = state;
    case (state)
      lut3d_pkg::ST_IDLE:  if (start) state_next = lut3d_pkg::ST_RUN;
      lut3d_pkg::ST_RUN:   if (k == 3'd7) state_next = lut3d_pkg::ST_DRAIN;
      lut3d_pkg::ST_DRAIN: if (!v1 && !v2 && !v3) state_next = lut3d_pkg::ST_DONE;
      lut3d_pkg::ST_DONE:  if (finish) state_next = lut3d_pkg::ST_IDLE;
      default:             state_next = lut3d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lut3d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= 3'd0;
    end else if (start) begin
      k <= 3'd0;
    end else if (rd_en) begin
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) cur <= job;
  end

  // corner offset: r bit, g bit, b bit of k
  always_comb begin
    offset = lut3d_pkg::POS_W'(k[0]);
    if (k[1]) offset = offset + lut3d_pkg::POS_W'(geff);
    if (k[2]) offset = offset + lut3d_pkg::POS_W'(gsq);
  end
  assign rd_addr = AW'(cur.pos + offset);

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(job.pos)][job.chan] <= job.value;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign fa = k[0] ? FW'(cur.frac0) : (lut3d_pkg::ONE_Q16 - FW'(cur.frac0));
  assign fb = k[1] ? FW'(cur.frac1) : (lut3d_pkg::ONE_Q16 - FW'(cur.frac1));
  assign fc = k[2] ? FW'(cur.frac2) : (lut3d_pkg::ONE_Q16 - FW'(cur.frac2));
  assign p012 = (3*FW)'(p01) * (3*FW)'(f2_1) + (3*FW)'(64'h8000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p01  <= (2*FW)'(fa) * (2*FW)'(fb);
    f2_1 <= fc;
    w    <= p012[FW+31:32];
    d2   <= rd_data;
    for (int c = 0; c < 4; c++) begin
      prod[c] <= $signed({1'b0, w}) * $signed(d2[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      if (start) acc[c] <= '0;
      else if (v3) acc[c] <= acc[c] + AccW'(prod[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd[c] = (acc[c] + AccW'(32768)) >>> 16;
      if (rnd[c] > AccW'(32767)) sat[c] = 16'sh7fff;
      else if (rnd[c] < -AccW'(32768)) sat[c] = -16'sh8000;
      else sat[c] = rnd[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.chan0 <= sat[0];
      result.chan1 <= sat[1];
      result.chan2 <= sat[2];
      result.chan3 <= sat[3];
    end
  end

  `LUT_ASSERT(a_idle_empty, (state == lut3d_pkg::ST_IDLE) |-> (!v1 && !v2 && !v3), "corner pipeline busy while idle")
  `LUT_NEVER(a_pop_busy, q_pop && (state != lut3d_pkg::ST_IDLE), "job taken while busy")
  `LUT_ASSERT(a_run_end, (state == lut3d_pkg::ST_RUN && k == 3'd7) |=> (state == lut3d_pkg::ST_DRAIN), "corner sweep overran")

endmodule

### hw/rtl/lut3d_trilinear_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_trilinear_interp
// Four-channel 3D LUT with trilinear interpolation, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (valid/ready): cmd 0 loads one table entry, cmd 1 sends a
//   pixel. Loads give no result; a load with an index past the table is
//   dropped. Each pixel gives one transaction on the result channel.
//   cfg_we/cfg_wdata set grid_size; write only while the block is idle.
//   Values below 2 act as 2, above MAX_GRID as MAX_GRID.
// Timing:
//   The front stage takes a transaction per cycle, while the queue has room,
//   into a two-deep job queue. A load is written to the table as the back
//   end takes it. A pixel occupies the back end for these steps: take the
//   job, eight corner reads from the single table read port, drain the
//   weight and multiply-accumulate stages, post the result. No new job is
//   taken until the result is posted.
// Reset:
//   Clears control state and sets grid_size to 17; table contents stay
//   undefined until loaded.
// Stall:
//   A held result blocks the back end at its last step; the queue and front
//   keep accepting until full, then item_ready drops.
// ----------------------------------------------------------------------------
module lut3d_trilinear_interp #(
  parameter int MAX_GRID = lut3d_pkg::MAX_GRID_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  lut3d_pkg::item_t             item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output lut3d_pkg::result_t           result,
  input  logic                         cfg_we,
  input  logic [lut3d_pkg::GRID_W-1:0] cfg_wdata
);

  logic [lut3d_pkg::GRID_W-1:0] grid_size;
  logic [lut3d_pkg::GRID_W-1:0] geff;
  logic [lut3d_pkg::SQ_W-1:0]   gsq;

  logic            fq_valid, fq_ready;
  lut3d_pkg::job_t fq_job;
  logic            qb_valid, qb_ready;
  lut3d_pkg::job_t qb_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= lut3d_pkg::GRID_RESET;
    end else if (cfg_we) begin
      grid_size <= cfg_wdata;
    end
  end

  always_comb begin
    if (grid_size < lut3d_pkg::GRID_W'(2)) geff = lut3d_pkg::GRID_W'(2);
    else if (32'(grid_size) > MAX_GRID) geff = lut3d_pkg::GRID_W'(MAX_GRID);
    else geff = grid_size;
  end

  always_ff @(posedge clk) begin
    gsq <= lut3d_pkg::SQ_W'(geff) * lut3d_pkg::SQ_W'(geff);
  end

  lut3d_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .geff       (geff),
    .gsq        (gsq),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job        (fq_job)
  );

  lut3d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  lut3d_back #(.MAX_GRID(MAX_GRID)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (qb_valid),
    .job_ready    (qb_ready),
    .job          (qb_job),
    .geff         (geff),
    .gsq          (gsq),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
